/* hdl/osvf_pkg.sv */
// Shared types, widths and constants of the oversampled state-variable filter.
package osvf_pkg;

    // Default configuration of the top level
    localparam int DEF_CHANNELS    = 2;
    localparam int DEF_SAMPLE_BITS = 24;

    // Fixed datapath widths
    localparam int CFG_W     = 17;   // Q1.16 configuration registers
    localparam int REG_IDX_W = 2;    // configuration register index
    localparam int COEF_W    = 17;   // Q1.16 frequency coefficient
    localparam int ANGLE_W   = 24;   // Q24 angle and its powers
    localparam int S_W       = 26;   // Q24 sine accumulator with headroom
    localparam int INTEG_W   = 32;   // saturating integrators
    localparam int SUM_W     = 34;   // sum of three lowpass values
    localparam int HP_W      = 35;   // unsaturated highpass value
    localparam int DAMP_W    = 18;   // signed damping, one minus rez_mod
    localparam int MUL_A_W   = 25;   // shared multiplier, operand A (signed)
    localparam int MUL_B_W   = 35;   // shared multiplier, operand B (signed)
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = 45;   // integrator update before saturation
    localparam int AVG_W     = PROD_W - 24;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_CUTOFF_CH0 = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CUTOFF_CH1 = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_CUTOFF = 2'd2;

    // Configuration values
    localparam logic [CFG_W-1:0] CUTOFF_ONE     = 17'd65536;
    localparam logic [CFG_W-1:0] CUTOFF_RST     = 17'd19661;
    localparam logic [CFG_W-1:0] MIN_CUTOFF_RST = 17'd27;

    // Arithmetic constants in Q24
    localparam logic [23:0] ANGLE_K     = 24'd8714969;   // 2*pi^2/38
    localparam logic [21:0] INV6_Q24    = 22'd2796203;   // 1/3!
    localparam logic [17:0] INV120_Q24  = 18'd139810;    // 1/5!
    localparam logic [11:0] INV5040_Q24 = 12'd3329;      // 1/7!
    localparam logic [22:0] THIRD_Q24   = 23'd5592405;   // 1/3
    localparam logic [26:0] F_ROUND     = 27'd128;       // Q24 to Q1.16 rounding

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_WB,
        ST_DONE
    } state_t;

    // Multiply operations, in issue order
    typedef enum logic [3:0] {
        OP_ANGLE,
        OP_X2,
        OP_X3,
        OP_T3,
        OP_X5,
        OP_T5,
        OP_X7,
        OP_T7,
        OP_FBP,
        OP_DBP,
        OP_FHP,
        OP_AVG
    } op_t;

endpackage

/* hdl/oversampled_state_variable_filter.sv */
// Oversampled Chamberlin state-variable filter on one shared multiplier.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------------
//  input    | in        | in_valid / in_stall | channel, sample, rez_mod
//  output   | out       | out_valid/out_stall | channel_out, lowpass_out
//  config   | in        | cfg_wr_en           | cfg_index, cfg_data
//
// One transaction runs from acceptance to the output register through 18 products
// (8 for the Taylor sine coefficient, 3 per filter pass, 1 for the average), each one
// a multiply state on the shared multiplier then a write-back state, and a hand-off state.
// in_stall holds from acceptance to the hand-off, so no new transaction is accepted before then.
// A finished result waits in the output register while the next transaction is accepted.
// Reset clears the integrators of all channels and loads the configuration defaults.
module oversampled_state_variable_filter #(
    parameter int CHANNELS    = osvf_pkg::DEF_CHANNELS,
    parameter int SAMPLE_BITS = osvf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [osvf_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [osvf_pkg::CFG_W-1:0]           cfg_data,
    // input transactions
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 channel,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    input  logic [osvf_pkg::CFG_W-1:0]           rez_mod,
    // output transactions
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 channel_out,
    output logic signed [SAMPLE_BITS-1:0]        lowpass_out
);
    import osvf_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration registers
    logic [CFG_W-1:0] cutoff_ch0_reg;
    logic [CFG_W-1:0] cutoff_ch1_reg;
    logic [CFG_W-1:0] min_cutoff_reg;

    // Sequencer
    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [1:0]       pass_reg;
    logic             accept;
    logic             mul_en;
    logic             wb_en;
    logic             load_out;

    // Per-channel integrators
    logic signed [INTEG_W-1:0] lp_state_reg [0:CHANNELS-1];
    logic signed [INTEG_W-1:0] bp_state_reg [0:CHANNELS-1];

    // Transaction context
    logic [IDX_W-1:0]          idx_in;
    logic [CFG_W-1:0]          cut_sel;
    logic [CFG_W-1:0]          cut_lo;
    logic [CFG_W-1:0]          cut_clamped;
    logic [IDX_W-1:0]          idx_reg;
    logic                      chan_reg;
    logic [CFG_W-1:0]          cut_reg;
    logic signed [INTEG_W-1:0] smp_reg;
    logic signed [DAMP_W-1:0]  damp_reg;

    // Coefficient datapath
    logic [ANGLE_W-1:0]        ang_reg;
    logic [ANGLE_W-1:0]        p2_reg;
    logic [ANGLE_W-1:0]        pw_reg;
    logic signed [S_W-1:0]     s_reg;
    logic [COEF_W-1:0]         f_reg;

    // Filter datapath
    logic signed [INTEG_W-1:0] lp_reg;
    logic signed [INTEG_W-1:0] bp_reg;
    logic signed [HP_W-1:0]    hp_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SAMPLE_BITS-1:0] res_reg;

    // Shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;

    // Write-back terms
    logic [ANGLE_W-1:0]        ang_new;
    logic [ANGLE_W-1:0]        pow_new;
    logic signed [S_W-1:0]     s_t7;
    logic [26:0]               f_round;
    logic [COEF_W-1:0]         f_new;
    logic signed [PROD_W-17:0] prod_sh16;
    logic signed [INTEG_W-1:0] acc_base;
    logic signed [ACC_W-1:0]   acc_full;
    logic [ACC_W-INTEG_W:0]    acc_hi;
    logic signed [INTEG_W-1:0] acc_sat;
    logic signed [HP_W-1:0]    hp_new;
    logic signed [AVG_W-1:0]   avg_full;
    logic [AVG_W-SAMPLE_BITS:0] avg_hi;
    logic signed [SAMPLE_BITS-1:0] avg_sat;

    // Output register
    logic                      out_valid_reg;
    logic                      channel_out_reg;
    logic signed [SAMPLE_BITS-1:0] lowpass_out_reg;

    // ------------------------------------------------------------------
    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_ch0_reg <= CUTOFF_RST;
            cutoff_ch1_reg <= CUTOFF_RST;
            min_cutoff_reg <= MIN_CUTOFF_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CUTOFF_CH0: cutoff_ch0_reg <= cfg_data;
                REG_CUTOFF_CH1: cutoff_ch1_reg <= cfg_data;
                REG_MIN_CUTOFF: min_cutoff_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_WB;
            ST_WB:   state_next = (op_reg == OP_AVG) ? ST_DONE : ST_MUL;
            ST_DONE: if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        accept   = (state_reg == ST_IDLE) && in_valid;
        mul_en   = (state_reg == ST_MUL);
        wb_en    = (state_reg == ST_WB);
        load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    end

    // Next operation
    always_comb
    begin
        unique case (op_reg)
            OP_ANGLE: op_next = OP_X2;
            OP_X2:    op_next = OP_X3;
            OP_X3:    op_next = OP_T3;
            OP_T3:    op_next = OP_X5;
            OP_X5:    op_next = OP_T5;
            OP_T5:    op_next = OP_X7;
            OP_X7:    op_next = OP_T7;
            OP_T7:    op_next = OP_FBP;
            OP_FBP:   op_next = OP_DBP;
            OP_DBP:   op_next = OP_FHP;
            OP_FHP:   op_next = (pass_reg == 2'd2) ? OP_AVG : OP_FBP;
            OP_AVG:   op_next = OP_ANGLE;
            default:  op_next = OP_ANGLE;
        endcase
    end

    // Advance state, operation and pass count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_ANGLE;
            pass_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                op_reg   <= OP_ANGLE;
                pass_reg <= 2'd0;
            end
            else if (wb_en)
            begin
                op_reg <= op_next;
                if (op_reg == OP_FHP)
                    pass_reg <= pass_reg + 2'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Select channel and clamp its cutoff
    always_comb
    begin
        idx_in      = (CHANNELS > 1) ? IDX_W'(channel) : '0;
        cut_sel     = (idx_in == '0) ? cutoff_ch0_reg : cutoff_ch1_reg;
        cut_lo      = (cut_sel < min_cutoff_reg) ? min_cutoff_reg : cut_sel;
        cut_clamped = (cut_lo > CUTOFF_ONE) ? CUTOFF_ONE : cut_lo;
    end

    // Multiplier operand select
    always_comb
    begin
        unique case (op_reg)
            OP_ANGLE:
            begin
                mul_a = MUL_A_W'(cut_reg);
                mul_b = MUL_B_W'(ANGLE_K);
            end
            OP_X2:
            begin
                mul_a = MUL_A_W'(ang_reg);
                mul_b = MUL_B_W'(ang_reg);
            end
            OP_X3:
            begin
                mul_a = MUL_A_W'(p2_reg);
                mul_b = MUL_B_W'(ang_reg);
            end
            OP_T3:
            begin
                mul_a = MUL_A_W'(INV6_Q24);
                mul_b = MUL_B_W'(pw_reg);
            end
            OP_X5, OP_X7:
            begin
                mul_a = MUL_A_W'(p2_reg);
                mul_b = MUL_B_W'(pw_reg);
            end
            OP_T5:
            begin
                mul_a = MUL_A_W'(INV120_Q24);
                mul_b = MUL_B_W'(pw_reg);
            end
            OP_T7:
            begin
                mul_a = MUL_A_W'(INV5040_Q24);
                mul_b = MUL_B_W'(pw_reg);
            end
            OP_FBP:
            begin
                mul_a = MUL_A_W'(f_reg);
                mul_b = MUL_B_W'(bp_reg);
            end
            OP_DBP:
            begin
                mul_a = MUL_A_W'(damp_reg);
                mul_b = MUL_B_W'(bp_reg);
            end
            OP_FHP:
            begin
                mul_a = MUL_A_W'(f_reg);
                mul_b = MUL_B_W'(hp_reg);
            end
            OP_AVG:
            begin
                mul_a = MUL_A_W'(THIRD_Q24);
                mul_b = MUL_B_W'(sum_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Write-back arithmetic: product shifts, Taylor terms, saturating integrator add
    always_comb
    begin
        ang_new   = prod_reg[ANGLE_W+15:16];
        pow_new   = prod_reg[ANGLE_W+23:24];
        s_t7      = s_reg - S_W'(pow_new);
        f_round   = {s_t7, 1'b0} + F_ROUND;
        f_new     = f_round[COEF_W+7:8];
        prod_sh16 = prod_reg[PROD_W-1:16];

        acc_base  = (op_reg == OP_FBP) ? lp_reg : bp_reg;
        acc_full  = ACC_W'(acc_base) + ACC_W'(prod_sh16);
        acc_hi    = acc_full[ACC_W-1:INTEG_W-1];
        if ((&acc_hi) || !(|acc_hi))
            acc_sat = acc_full[INTEG_W-1:0];
        else
            acc_sat = acc_full[ACC_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                        : {1'b0, {(INTEG_W-1){1'b1}}};

        hp_new    = HP_W'(smp_reg) - HP_W'(lp_reg) - HP_W'(prod_sh16);

        avg_full  = prod_reg[PROD_W-1:24];
        avg_hi    = avg_full[AVG_W-1:SAMPLE_BITS-1];
        if ((&avg_hi) || !(|avg_hi))
            avg_sat = avg_full[SAMPLE_BITS-1:0];
        else
            avg_sat = avg_full[AVG_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                        : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end

    // Load context, multiply, write back
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg  <= idx_in;
            chan_reg <= channel;
            cut_reg  <= cut_clamped;
            smp_reg  <= INTEG_W'(sample);
            damp_reg <= DAMP_W'(CUTOFF_ONE) - DAMP_W'(rez_mod);
            lp_reg   <= lp_state_reg[idx_in];
            bp_reg   <= bp_state_reg[idx_in];
            sum_reg  <= '0;
        end
        if (mul_en)
            prod_reg <= mul_a * mul_b;
        if (wb_en)
        begin
            unique case (op_reg)
                OP_ANGLE:
                begin
                    ang_reg <= ang_new;
                    s_reg   <= S_W'(ang_new);
                end
                OP_X2:               p2_reg <= pow_new;
                OP_X3, OP_X5, OP_X7: pw_reg <= pow_new;
                OP_T3:               s_reg  <= s_reg - S_W'(pow_new);
                OP_T5:               s_reg  <= s_reg + S_W'(pow_new);
                OP_T7:               f_reg  <= f_new;
                OP_FBP:              lp_reg <= acc_sat;
                OP_DBP:
                begin
                    hp_reg  <= hp_new;
                    sum_reg <= sum_reg + SUM_W'(lp_reg);
                end
                OP_FHP:              bp_reg  <= acc_sat;
                OP_AVG:              res_reg <= avg_sat;
                default: ;
            endcase
        end
    end

    // Store integrators after the third pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                lp_state_reg[i] <= '0;
                bp_state_reg[i] <= '0;
            end
        end
        else if (wb_en && (op_reg == OP_FHP) && (pass_reg == 2'd2))
        begin
            lp_state_reg[idx_reg] <= lp_reg;
            bp_state_reg[idx_reg] <= acc_sat;
        end
    end

    // ------------------------------------------------------------------
    // Output register: load a finished result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            channel_out_reg <= chan_reg;
            lowpass_out_reg <= res_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign channel_out = channel_out_reg;
    assign lowpass_out = lowpass_out_reg;

    // ------------------------------------------------------------------
    // Checks

    // An accepted transaction starts the sequence at the angle product
    a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_MUL) && (op_reg == OP_ANGLE))
        else $error("sequence did not start at the angle product");

    // The average is taken only after three filter passes
    a_three_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (wb_en && (op_reg == OP_AVG)) |-> (pass_reg == 2'd3))
        else $error("average taken before three filter passes");

    // The frequency coefficient never exceeds one
    a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wb_en && (op_reg == OP_T7)) |=> (f_reg <= CUTOFF_ONE))
        else $error("frequency coefficient above one");

    // A new result appears only from the hand-off state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("output raised outside the hand-off state");

    // The multiplier is never busy while the block takes input
    a_idle_mul: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !mul_en && !wb_en)
        else $error("multiplier active while accepting input");

endmodule
